/* hdl/pctd_pkg.sv */
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_MAX_CODE_BITS = 32;
    localparam int DEF_SYMBOL_BITS   = 16;

    localparam int INDEX_W  = 6;
    localparam int ESYM_W   = 16;
    localparam int ELEN_W   = 6;
    localparam int ECODE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int OSYM_W   = 16;

    localparam int GROUP_SIZE = 8;
    localparam int GRP_W      = $clog2(GROUP_SIZE);
    localparam int BITCNT_W   = $clog2(BYTE_W + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic res;
        logic err;
        logic fin;
    } t_evt;

endpackage

/* hdl/pctd_if.sv */
`timescale 1ns / 1ps

interface pctd_in_if import pctd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [ESYM_W-1:0]  entry_symbol;
    logic [ELEN_W-1:0]  entry_length;
    logic [ECODE_W-1:0] entry_code;
    logic [BYTE_W-1:0]  data_byte;
    logic               start_of_stream;

    modport source (output valid, mode, entry_index, entry_symbol, entry_length,
                    entry_code, data_byte, start_of_stream, input ready);
    modport sink   (input valid, mode, entry_index, entry_symbol, entry_length,
                    entry_code, data_byte, start_of_stream, output ready);
endinterface

interface pctd_out_if import pctd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OSYM_W-1:0] symbol;
    logic              error;
    logic              last;

    modport source (output valid, symbol, error, last, input ready);
    modport sink   (input valid, symbol, error, last, output ready);
endinterface

/* hdl/prefix_code_table_decoder.sv */
`timescale 1ns / 1ps

// Prefix-code decoder with a loadable table. A load item (mode 0) writes one slot;
// a data item (mode 1) is shifted in one bit per cycle, most significant bit
// first, and each bit is compared against every table slot in parallel; the next
// byte is accepted only once the bit engine has shifted in the final bit of the
// current one. Each match or error becomes one result item, with last marking the
// final result of its byte; a result is held until the next result or the end of
// its byte decides last, and passes through registers s1, s2 and s3, the pending
// register and the output register. The engine holds while the output is stalled,
// and while a final result that came from the final bit of its byte waits in the
// pending register. A load waits while a result of the two latest bits still reads
// its symbol. Lowest slot wins when several codes match.

module prefix_code_table_decoder import pctd_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
    parameter int SYMBOL_BITS   = DEF_SYMBOL_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pctd_in_if.sink   i_in,
    pctd_out_if.source o_out
);

    localparam int TBL_IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int LEN_W      = $clog2(MAX_CODE_BITS + 1);
    localparam int NUM_GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    logic [ELEN_W-1:0]        r_tbl_len  [TABLE_ENTRIES];
    logic [MAX_CODE_BITS-1:0] r_tbl_code [TABLE_ENTRIES];

    logic                     r_busy;
    logic [BITCNT_W-1:0]      r_bits_left;
    logic [BYTE_W-1:0]        r_shift;
    logic [MAX_CODE_BITS-1:0] r_acc_bits;
    logic [LEN_W-1:0]         r_acc_len;

    t_evt                     r_s1_evt, r_s2_evt, r_s3_evt;
    logic [TABLE_ENTRIES-1:0] r_s1_hits;
    logic [GRP_W-1:0]         r_s2_loc [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]    r_s2_any;

    logic                     r_pend_valid;
    logic                     r_pend_last;
    logic [OSYM_W-1:0]        r_pend_sym;
    logic                     r_pend_err;

    logic                     r_out_valid;
    logic [OSYM_W-1:0]        r_out_sym;
    logic                     r_out_err;
    logic                     r_out_last;

    logic                     w_in_fire;
    logic                     w_out_free;
    logic                     w_adv;
    logic                     w_step;
    logic                     w_flush;

    logic [MAX_CODE_BITS-1:0] w_n_acc;
    logic [LEN_W-1:0]         w_n_len;
    logic [MAX_CODE_BITS-1:0] w_mask;
    logic [TABLE_ENTRIES-1:0] w_hits;
    logic                     w_hit_any;
    logic                     w_err_now;
    t_evt                     w_evt;

    logic [PAD_W-1:0]         w_hits_pad;
    logic [GRP_W-1:0]         w_loc [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]    w_any;
    logic [GW-1:0]            w_grp;
    logic [GRP_W-1:0]         w_grp_loc;
    logic [GW+GRP_W-1:0]      w_slot_wide;

    logic [8:0]               w_idx_wide;
    logic [TBL_IDX_W-1:0]     w_wr_idx;
    logic                     w_tbl_wr;
    logic [31:0]              w_sym_wide;
    logic [SYMBOL_BITS-1:0]   w_rd_sym;
    logic [31:0]              w_rd_wide;
    logic [OSYM_W-1:0]        w_s3_sym;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_flush    = r_pend_valid && r_pend_last;
    assign w_adv      = w_out_free && !w_flush;
    assign w_step     = r_busy && w_adv;

    assign i_in.ready = !r_busy
        && ((i_in.mode == MODE_DATA) || !(r_s1_evt.res || r_s2_evt.res));
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign w_idx_wide = 9'(i_in.entry_index);
    assign w_wr_idx   = w_idx_wide[TBL_IDX_W-1:0];
    assign w_tbl_wr   = w_in_fire && (i_in.mode == MODE_LOAD)
                        && (w_idx_wide < 9'(TABLE_ENTRIES));
    assign w_sym_wide = 32'(i_in.entry_symbol);

    // bit engine: accumulate one bit and compare against every slot
    always_comb begin
        w_n_acc   = {r_acc_bits[MAX_CODE_BITS-2:0], r_shift[BYTE_W-1]};
        w_n_len   = LEN_W'(r_acc_len + LEN_W'(1));
        for (int j = 0; j < MAX_CODE_BITS; j++) begin
            w_mask[j] = LEN_W'(j) < w_n_len;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hits[i] = (r_tbl_len[i] == ELEN_W'(w_n_len))
                        && (((r_tbl_code[i] ^ w_n_acc) & w_mask) == '0);
        end
        w_hit_any = |w_hits;
        w_err_now = !w_hit_any && (w_n_len >= LEN_W'(MAX_CODE_BITS));
        w_evt.res = w_step && (w_hit_any || w_err_now);
        w_evt.err = w_err_now;
        w_evt.fin = w_step && (r_bits_left == BITCNT_W'(1));
    end

    // lowest hit inside each group of slots
    always_comb begin
        w_hits_pad = PAD_W'(r_s1_hits);
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_loc[g] = '0;
            for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
                if (w_hits_pad[g*GROUP_SIZE + k]) begin
                    w_loc[g] = GRP_W'(k);
                end
            end
            w_any[g] = |w_hits_pad[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    // lowest group with a hit selects the symbol slot
    always_comb begin
        w_grp     = '0;
        w_grp_loc = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (r_s2_any[g]) begin
                w_grp     = GW'(g);
                w_grp_loc = r_s2_loc[g];
            end
        end
        w_slot_wide = {w_grp, w_grp_loc};
    end

    pctd_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_sym_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_tbl_wr),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_sym_wide[SYMBOL_BITS-1:0]),
        .i_rd_en   (w_adv && r_s2_evt.res),
        .i_rd_addr (w_slot_wide[TBL_IDX_W-1:0]),
        .o_rd_data (w_rd_sym)
    );

    assign w_rd_wide = 32'(w_rd_sym);
    assign w_s3_sym  = r_s3_evt.err ? '0 : w_rd_wide[OSYM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_tbl_len[i] <= '0;
            end
        end else if (w_tbl_wr) begin
            r_tbl_len[w_wr_idx] <= i_in.entry_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_wr) begin
            r_tbl_code[w_wr_idx] <= i_in.entry_code[MAX_CODE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_bits_left <= '0;
            r_acc_bits  <= '0;
            r_acc_len   <= '0;
        end else if (w_in_fire && (i_in.mode == MODE_DATA)) begin
            r_busy      <= 1'b1;
            r_bits_left <= BITCNT_W'(BYTE_W);
            if (i_in.start_of_stream) begin
                r_acc_bits <= '0;
                r_acc_len  <= '0;
            end
        end else if (w_step) begin
            r_bits_left <= BITCNT_W'(r_bits_left - BITCNT_W'(1));
            r_busy      <= (r_bits_left != BITCNT_W'(1));
            if (w_evt.res) begin
                r_acc_bits <= '0;
                r_acc_len  <= '0;
            end else begin
                r_acc_bits <= w_n_acc;
                r_acc_len  <= w_n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && (i_in.mode == MODE_DATA)) begin
            r_shift <= i_in.data_byte;
        end else if (w_step) begin
            r_shift <= {r_shift[BYTE_W-2:0], 1'b0};
        end
    end

    // advance the result pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_evt <= '0;
            r_s2_evt <= '0;
            r_s3_evt <= '0;
        end else if (w_adv) begin
            r_s1_evt <= w_evt;
            r_s2_evt <= r_s1_evt;
            r_s3_evt <= r_s2_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_hits <= w_hits;
            r_s2_any  <= w_any;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_s2_loc[g] <= w_loc[g];
            end
        end
    end

    // hold one result until the next one or the end of its byte decides last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_flush) begin
                if (w_out_free) begin
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                    r_pend_last  <= 1'b0;
                end
            end else if (w_adv) begin
                if (r_s3_evt.res) begin
                    if (r_pend_valid) begin
                        r_out_valid <= 1'b1;
                    end
                    r_pend_valid <= 1'b1;
                    r_pend_last  <= r_s3_evt.fin;
                end else if (r_s3_evt.fin && r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flush) begin
            if (w_out_free) begin
                r_out_sym  <= r_pend_sym;
                r_out_err  <= r_pend_err;
                r_out_last <= 1'b1;
            end
        end else if (w_adv) begin
            if (r_s3_evt.res) begin
                r_out_sym  <= r_pend_sym;
                r_out_err  <= r_pend_err;
                r_out_last <= 1'b0;
                r_pend_sym <= w_s3_sym;
                r_pend_err <= r_s3_evt.err;
            end else if (r_s3_evt.fin) begin
                r_out_sym  <= r_pend_sym;
                r_out_err  <= r_pend_err;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.symbol = r_out_sym;
    assign o_out.error  = r_out_err;
    assign o_out.last   = r_out_last;

    a_err_no_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.symbol == '0)
        else $error("error result carries a symbol");

    a_flush_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && r_pend_last |-> !w_adv && !w_step)
        else $error("pipeline advanced while a final result waits");

    a_acc_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_len < LEN_W'(MAX_CODE_BITS))
        else $error("accumulator passed the maximum code length");

    a_data_starts_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && (i_in.mode == MODE_DATA) |=> r_busy && (r_bits_left == BITCNT_W'(BYTE_W)))
        else $error("accepted byte did not start the bit engine");

endmodule

/* hdl/pctd_ram.sv */
`timescale 1ns / 1ps

module pctd_ram import pctd_pkg::*; #(
    parameter int WIDTH = DEF_SYMBOL_BITS,
    parameter int DEPTH = DEF_TABLE_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench import pctd_pkg::*; ();

    localparam int TABLE_SLOTS  = DEF_TABLE_ENTRIES;
    localparam int CODE_BITS    = DEF_MAX_CODE_BITS;
    localparam int RANDOM_ITEMS = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_N   = 25;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] entry_index;
        logic [ESYM_W-1:0]  entry_symbol;
        logic [ELEN_W-1:0]  entry_length;
        logic [ECODE_W-1:0] entry_code;
        logic [BYTE_W-1:0]  data_byte;
        logic               start_of_stream;
    } t_code_item;

    typedef struct packed {
        logic [OSYM_W-1:0] symbol;
        logic              error;
        logic              last;
    } t_sym_result;

    typedef struct {
        t_code_item        item;
        bit                typed;
        int                n_exp;
        logic [OSYM_W-1:0] exp_sym;
        logic              exp_err;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    pctd_in_if  in_ch ();
    pctd_out_if out_ch ();

    prefix_code_table_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [ECODE_W-1:0] slot_code [TABLE_SLOTS] = '{default: '0};
    logic [ELEN_W-1:0]  slot_len  [TABLE_SLOTS] = '{default: '0};
    logic [OSYM_W-1:0]  slot_sym  [TABLE_SLOTS] = '{default: '0};
    logic [CODE_BITS-1:0] acc_bits = '0;
    int                   acc_len  = 0;

    t_sym_result fresh_results [$];
    t_sym_result pending_symbols [$];

    int          fail_count   = 0;
    int          item_count   = 0;
    int          byte_count   = 0;
    int          symbols_seen = 0;
    int          errors_seen  = 0;
    int          tables_built = 0;
    int          burst_left   = 8;
    bit          offering     = 1'b0;
    bit          hold_req     = 1'b0;
    int unsigned cycle_count  = 0;

    t_directed_row directed_rows [DIRECTED_N] = '{
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h00, 1'b1}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hFF, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hA5, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h5A, 1'b0}, 1, 1, 16'h0, 1},
        '{'{MODE_LOAD, 6'd0,  16'hFFFF, 6'd1,  32'h0000_0000, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h00, 1'b1}, 1, 8, 16'hFFFF, 0},
        '{'{MODE_LOAD, 6'd63, 16'h0000, 6'd1,  32'hFFFF_FFFF, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hFF, 1'b0}, 1, 8, 16'h0000, 0},
        '{'{MODE_LOAD, 6'd1,  16'h1234, 6'd1,  32'h0000_0000, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h00, 1'b0}, 1, 8, 16'hFFFF, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h0F, 1'b0}, 0, 0, 16'h0, 0},
        '{'{MODE_LOAD, 6'd0,  16'hAAAA, 6'd0,  32'h5555_5555, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h3C, 1'b0}, 0, 0, 16'h0, 0},
        '{'{MODE_LOAD, 6'd63, 16'h5555, 6'd33, 32'hFFFF_FFFF, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hF0, 1'b1}, 0, 0, 16'h0, 0},
        '{'{MODE_LOAD, 6'd1,  16'h0000, 6'd0,  32'h0000_0000, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_LOAD, 6'd2,  16'hBEEF, 6'd32, 32'hDEAD_BEEF, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hDE, 1'b1}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hAD, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hBE, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hEF, 1'b0}, 1, 1, 16'hBEEF, 0},
        '{'{MODE_LOAD, 6'd3,  16'h0101, 6'd3,  32'h0000_0005, 8'h00, 1'b0}, 1, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hA0, 1'b1}, 0, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'h00, 1'b0}, 0, 0, 16'h0, 0},
        '{'{MODE_DATA, 6'd0,  16'h0000, 6'd0,  32'h0000_0000, 8'hA0, 1'b1}, 0, 0, 16'h0, 0}
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void decode_item(input t_code_item it);
        logic [CODE_BITS-1:0] mask;
        int                   hit;
        t_sym_result          r;
        fresh_results.delete();
        if (it.mode == MODE_LOAD) begin
            slot_sym[it.entry_index]  = it.entry_symbol;
            slot_len[it.entry_index]  = it.entry_length;
            slot_code[it.entry_index] = it.entry_code;
            return;
        end
        if (it.start_of_stream) begin
            acc_bits = '0;
            acc_len  = 0;
        end
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            acc_bits = {acc_bits[CODE_BITS-2:0], it.data_byte[b]};
            acc_len++;
            mask = (acc_len >= CODE_BITS) ? '1 : ((CODE_BITS'(1) << acc_len) - 1'b1);
            hit  = -1;
            for (int i = 0; i < TABLE_SLOTS && hit < 0; i++) begin
                if (slot_len[i] != 0 && slot_len[i] == acc_len &&
                    ((slot_code[i] ^ acc_bits) & mask) == '0)
                    hit = i;
            end
            if (hit >= 0 || acc_len >= CODE_BITS) begin
                r.symbol = (hit >= 0) ? slot_sym[hit] : '0;
                r.error  = (hit < 0);
                r.last   = 1'b0;
                fresh_results.insert(fresh_results.size(), r);
                acc_bits = '0;
                acc_len  = 0;
            end
        end
        if (fresh_results.size() > 0) begin
            r = fresh_results.pop_back();
            r.last = 1'b1;
            fresh_results.insert(fresh_results.size(), r);
        end
    endfunction

    function automatic t_code_item random_item(input logic mode);
        t_code_item it;
        it.mode            = mode;
        it.entry_index     = INDEX_W'($urandom());
        it.entry_symbol    = ESYM_W'($urandom());
        it.entry_length    = ELEN_W'($urandom());
        it.entry_code      = ECODE_W'($urandom());
        it.data_byte       = BYTE_W'($urandom());
        it.start_of_stream = ($urandom_range(0, 11) == 0);
        return it;
    endfunction

    task automatic send_item(input t_code_item it, input bit typed, input int n_exp,
                             input logic [OSYM_W-1:0] exp_sym, input logic exp_err);
        t_sym_result r;
        in_ch.mode            <= it.mode;
        in_ch.entry_index     <= it.entry_index;
        in_ch.entry_symbol    <= it.entry_symbol;
        in_ch.entry_length    <= it.entry_length;
        in_ch.entry_code      <= it.entry_code;
        in_ch.data_byte       <= it.data_byte;
        in_ch.start_of_stream <= it.start_of_stream;
        in_ch.valid           <= 1'b1;
        offering = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        decode_item(it);
        if (typed) begin
            for (int k = 0; k < n_exp; k++) begin
                r.symbol = exp_sym;
                r.error  = exp_err;
                r.last   = (k == n_exp - 1);
                pending_symbols.insert(pending_symbols.size(), r);
            end
        end else begin
            foreach (fresh_results[k])
                pending_symbols.insert(pending_symbols.size(), fresh_results[k]);
        end
        item_count++;
        if (it.mode == MODE_DATA) byte_count++;
        burst_left--;
        if (burst_left <= 0) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge i_clk); while (pending_symbols.size() != 0);
    endtask

    // stimulus
    initial begin
        int         leaf_code [$];
        int         leaf_len [$];
        int         n_leaves;
        int         pick;
        int         code_val;
        int         len_val;
        int         base;
        int         stride;
        int         slot;
        int         drop;
        int         n_bytes;
        int         phase;
        bit         deep;
        bit         new_slot [TABLE_SLOTS];
        t_code_item it;

        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.mode            <= MODE_LOAD;
        in_ch.entry_index     <= '0;
        in_ch.entry_symbol    <= '0;
        in_ch.entry_length    <= '0;
        in_ch.entry_code      <= '0;
        in_ch.data_byte       <= '0;
        in_ch.start_of_stream <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].n_exp,
                      directed_rows[r].exp_sym, directed_rows[r].exp_err);
        end

        phase = 0;
        while (phase < 3 || item_count - DIRECTED_N < RANDOM_ITEMS) begin
            if (phase == 2) wait_drained();

            // grow a random prefix tree by splitting leaves
            leaf_code = '{0, 1};
            leaf_len  = '{1, 1};
            n_leaves  = $urandom_range(2, 16);
            deep      = ($urandom_range(0, 3) == 0);
            while (leaf_code.size() < n_leaves) begin
                pick = deep ? leaf_code.size() - 1 : $urandom_range(0, leaf_code.size() - 1);
                code_val = leaf_code[pick];
                len_val  = leaf_len[pick];
                leaf_code.delete(pick);
                leaf_len.delete(pick);
                leaf_code.insert(leaf_code.size(), code_val << 1);
                leaf_len.insert(leaf_len.size(), len_val + 1);
                leaf_code.insert(leaf_code.size(), (code_val << 1) | 1);
                leaf_len.insert(leaf_len.size(), len_val + 1);
            end

            drop     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_leaves - 1) : -1;
            base     = $urandom_range(0, TABLE_SLOTS - 1);
            stride   = 2 * $urandom_range(0, TABLE_SLOTS / 2 - 1) + 1;
            new_slot = '{default: 1'b0};
            foreach (leaf_code[j]) begin
                slot = (base + j * stride) % TABLE_SLOTS;
                new_slot[slot] = 1'b1;
                it = random_item(MODE_LOAD);
                it.entry_index  = INDEX_W'(slot);
                it.entry_length = (j == drop) ? '0 : ELEN_W'(leaf_len[j]);
                it.entry_code   = ($urandom() << leaf_len[j]) | leaf_code[j];
                send_item(it, 0, 0, '0, 1'b0);
            end

            // shadow one code in a higher slot
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, n_leaves - 1);
                base = (base + pick * stride) % TABLE_SLOTS;
                slot = TABLE_SLOTS - 1;
                while (slot > base && new_slot[slot]) slot--;
                if (slot > base && pick != drop) begin
                    new_slot[slot] = 1'b1;
                    it = random_item(MODE_LOAD);
                    it.entry_index  = INDEX_W'(slot);
                    it.entry_length = ELEN_W'(leaf_len[pick]);
                    it.entry_code   = ($urandom() << leaf_len[pick]) | leaf_code[pick];
                    send_item(it, 0, 0, '0, 1'b0);
                end
            end

            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (!new_slot[s] && slot_len[s] != 0) begin
                    it = random_item(MODE_LOAD);
                    it.entry_index  = INDEX_W'(s);
                    it.entry_length = '0;
                    send_item(it, 0, 0, '0, 1'b0);
                end
            end
            tables_built++;

            if (phase == 1) hold_req = 1'b1;
            n_bytes = $urandom_range(12, 30);
            for (int b = 0; b < n_bytes; b++) begin
                slot = $urandom_range(0, TABLE_SLOTS - 1);
                if ($urandom_range(0, 9) == 0 && !new_slot[slot]) begin
                    it = random_item(MODE_LOAD);
                    it.entry_index  = INDEX_W'(slot);
                    it.entry_length = $urandom_range(0, 1) ? '0
                                                           : ELEN_W'($urandom_range(33, 63));
                    send_item(it, 0, 0, '0, 1'b0);
                end
                it = random_item(MODE_DATA);
                if (b == 0) it.start_of_stream = 1'b1;
                send_item(it, 0, 0, '0, 1'b0);
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items: %0d data bytes, %0d loads, %0d random code tables",
                 item_count, byte_count, item_count - byte_count, tables_built);
        $display("Checked %0d decoded symbols and %0d error results, %0d mismatches",
                 symbols_seen, errors_seen, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // receiver
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0: begin
                        repeat (n) begin
                            out_ch.ready <= 1'b1;
                            @(posedge i_clk);
                        end
                    end
                    1: begin
                        repeat (n) begin
                            out_ch.ready <= 1'($urandom_range(0, 1));
                            @(posedge i_clk);
                        end
                    end
                    default: begin
                        out_ch.ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_sym_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (out_ch.error === 1'b1) errors_seen++;
            else symbols_seen++;
            if (pending_symbols.size() == 0) begin
                $error("unexpected result: symbol %h error %b last %b",
                       out_ch.symbol, out_ch.error, out_ch.last);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (out_ch.symbol !== want.symbol) begin
                    $error("symbol: expected %h, got %h", want.symbol, out_ch.symbol);
                    fail_count++;
                end
                if (out_ch.error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, out_ch.error);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
